// File: rtl/core/l4cs_pkg.sv
package l4cs_pkg;

  typedef logic [1:0] kind_t;

  localparam logic [15:0] ETH_IPV4  = 16'h0800;
  localparam logic [15:0] ETH_IPV6  = 16'h86DD;
  localparam logic [7:0]  PROTO_TCP = 8'h06;
  localparam logic [7:0]  PROTO_UDP = 8'h11;

  localparam kind_t KIND_NONE = 2'd0;
  localparam kind_t KIND_TCP  = 2'd1;
  localparam kind_t KIND_UDP  = 2'd2;

  localparam logic [6:0] ETH_HDR_BYTES  = 7'd14;
  localparam logic [6:0] IPV6_SEG_START = 7'd54;
  localparam logic [6:0] IPV4_MIN_HDR   = 7'd20;
  localparam logic [6:0] TCP_CK_OFS     = 7'd16;
  localparam logic [6:0] UDP_CK_OFS     = 7'd6;
  localparam logic [6:0] TCP_MIN_SEG    = 7'd18;
  localparam logic [6:0] UDP_MIN_SEG    = 7'd8;

endpackage

// File: rtl/core/l4_checksum_recompute_unit.sv
// TCP/UDP checksum recompute over a streamed Ethernet frame.
// Input channel (in_*): one frame byte per transfer, in wire order; in_tlast
// marks the final byte. IPv4 (with options) and IPv6 (no extension headers)
// are decoded; the pseudo-header, the addresses and the layer-4 segment are
// summed with the stored checksum word taken as zero.
// Result channel (out_*): exactly one transfer per frame, carrying the
// checksum, the byte offset of its high byte and the segment kind
// (none, TCP, UDP). Kind none gives zero checksum and offset.
// Throughput: one byte per cycle while in_tready is high, set by the running-sum adder.
// After the last byte's transfer, the capture stage takes the final sum and
// the output register then takes it folded and inverted.
// Bytes past MAX_FRAME are dropped and the frame reports kind none.
// A stalled result holds in the output register; one more finished frame
// may wait in the fold stage, after which in_tready drops.
// Reset clears all frame state and both stage valids.
module l4_checksum_recompute_unit #(
  parameter int MAX_FRAME = 65535
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] frame_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [15:0] checksum_value, [22:16] field_offset, [23] zero
  output logic [1:0]  out_tuser   // [1:0] segment_kind
);

  localparam int PW = $clog2(MAX_FRAME + 1);

  // frame state
  logic [PW-1:0] pos_r, pos_nxt;
  logic [15:0]   eth_r, eth_nxt, eth_c;
  logic [6:0]    ihl_r, ihl_nxt, ihl_c;
  logic [7:0]    proto_r, proto_nxt, proto_c;
  logic [31:0]   sum_r, sum_nxt, sum_c;
  logic [7:0]    held_r, held_nxt, held_c;
  logic          over_r, over_nxt, over_c;

  // capture stage
  logic          p1_valid_r, p1_valid_nxt;
  logic [31:0]   p1_sum_r;
  logic [16:0]   p1_extra_r;
  logic          p1_ok_r;
  logic          p1_tcp_r;
  logic [6:0]    p1_ck_r;

  // result register
  logic          out_valid_r, out_valid_nxt;
  logic [15:0]   out_ck_r;
  logic [6:0]    out_ofs_r;
  l4cs_pkg::kind_t out_kind_r;

  logic          in_acc, byte_en, s2_ld;
  logic [PW-1:0] q;
  logic          is_v4, is_v6;
  logic [6:0]    start, ck, need;
  logic          sum_en;
  logic [PW-1:0] len;
  logic          ok;
  logic [16:0]   extra;
  logic [31:0]   total;
  logic [16:0]   fold1, fold2;

  assign s2_ld     = p1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !p1_valid_r || s2_ld;
  assign in_acc    = in_tvalid && in_tready;
  assign byte_en   = in_acc && (pos_r < PW'(MAX_FRAME));
  assign q         = {pos_r[PW-1:1], 1'b0};

  always_comb begin
    eth_c   = eth_r;
    ihl_c   = ihl_r;
    proto_c = proto_r;
    if (byte_en && pos_r == PW'(12)) eth_c = {in_tdata, 8'h00};
    if (byte_en && pos_r == PW'(13)) eth_c = {eth_r[15:8], in_tdata};
    if (byte_en && pos_r == PW'(14) && eth_c == l4cs_pkg::ETH_IPV4) begin
      ihl_c = {1'b0, in_tdata[3:0], 2'b00};
    end
    if (byte_en && pos_r == PW'(23) && eth_c == l4cs_pkg::ETH_IPV4) proto_c = in_tdata;
    if (byte_en && pos_r == PW'(20) && eth_c == l4cs_pkg::ETH_IPV6) proto_c = in_tdata;
  end

  always_comb begin
    is_v4 = (eth_c == l4cs_pkg::ETH_IPV4) && (ihl_c >= l4cs_pkg::IPV4_MIN_HDR);
    is_v6 = (eth_c == l4cs_pkg::ETH_IPV6);
    if (is_v4)      start = l4cs_pkg::ETH_HDR_BYTES + ihl_c;
    else if (is_v6) start = l4cs_pkg::IPV6_SEG_START;
    else            start = 7'd0;
    if (start == 7'd0)                        ck = 7'd0;
    else if (proto_c == l4cs_pkg::PROTO_TCP)  ck = start + l4cs_pkg::TCP_CK_OFS;
    else if (proto_c == l4cs_pkg::PROTO_UDP)  ck = start + l4cs_pkg::UDP_CK_OFS;
    else                                      ck = 7'd0;
    // word with high byte at q: addresses plus segment, minus the checksum word
    if (ck != 7'd0 && q == PW'(ck)) sum_en = 1'b0;
    else if (is_v4) sum_en = (q >= PW'(26) && q < PW'(34)) || (q >= PW'(start));
    else if (is_v6) sum_en = (q >= PW'(22));
    else            sum_en = 1'b0;
  end

  always_comb begin
    held_c = held_r;
    sum_c  = sum_r;
    over_c = over_r;
    if (in_acc && !byte_en) over_c = 1'b1;
    if (byte_en) begin
      if (!pos_r[0]) begin
        held_c = in_tdata;
        if (in_tlast && sum_en) sum_c = sum_r + {16'h0000, in_tdata, 8'h00};
      end else if (sum_en) begin
        sum_c = sum_r + {16'h0000, held_r, in_tdata};
      end
    end
    len  = byte_en ? pos_r + PW'(1) : pos_r;
    need = (proto_c == l4cs_pkg::PROTO_TCP) ? l4cs_pkg::TCP_MIN_SEG : l4cs_pkg::UDP_MIN_SEG;
    ok   = !over_c && (start != 7'd0) && (ck != 7'd0) && (len >= PW'(start + need));
    extra = 17'({8'h00, proto_c}) + 17'(len - PW'(start));
  end

  always_comb begin
    if (in_acc && in_tlast) begin
      pos_nxt   = '0;
      eth_nxt   = '0;
      ihl_nxt   = '0;
      proto_nxt = '0;
      sum_nxt   = '0;
      held_nxt  = '0;
      over_nxt  = 1'b0;
    end else begin
      pos_nxt   = len;
      eth_nxt   = eth_c;
      ihl_nxt   = ihl_c;
      proto_nxt = proto_c;
      sum_nxt   = sum_c;
      held_nxt  = held_c;
      over_nxt  = over_c;
    end
    if (in_acc && in_tlast) p1_valid_nxt = 1'b1;
    else if (s2_ld)         p1_valid_nxt = 1'b0;
    else                    p1_valid_nxt = p1_valid_r;
    if (s2_ld)           out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else                 out_valid_nxt = out_valid_r;
  end

  // end-around carry fold, twice
  always_comb begin
    total = p1_sum_r + {15'h0000, p1_extra_r};
    fold1 = {1'b0, total[31:16]} + {1'b0, total[15:0]};
    fold2 = {16'h0000, fold1[16]} + {1'b0, fold1[15:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      eth_r       <= '0;
      ihl_r       <= '0;
      proto_r     <= '0;
      sum_r       <= '0;
      held_r      <= '0;
      over_r      <= 1'b0;
      p1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      eth_r       <= eth_nxt;
      ihl_r       <= ihl_nxt;
      proto_r     <= proto_nxt;
      sum_r       <= sum_nxt;
      held_r      <= held_nxt;
      over_r      <= over_nxt;
      p1_valid_r  <= p1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_tlast) begin
      p1_sum_r   <= sum_c;
      p1_extra_r <= extra;
      p1_ok_r    <= ok;
      p1_tcp_r   <= (proto_c == l4cs_pkg::PROTO_TCP);
      p1_ck_r    <= ck;
    end
    if (s2_ld) begin
      if (p1_ok_r) begin
        out_ck_r   <= ~fold2[15:0];
        out_ofs_r  <= p1_ck_r;
        out_kind_r <= p1_tcp_r ? l4cs_pkg::KIND_TCP : l4cs_pkg::KIND_UDP;
      end else begin
        out_ck_r   <= 16'h0000;
        out_ofs_r  <= 7'd0;
        out_kind_r <= l4cs_pkg::KIND_NONE;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_ofs_r, out_ck_r};
  assign out_tuser  = out_kind_r;

  // frame state restarts after the final byte
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> (pos_r == '0 && sum_r == '0 && !over_r))
    else $error("frame state not cleared after last byte");

  a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == l4cs_pkg::KIND_NONE) |->
      (out_ck_r == 16'h0000 && out_ofs_r == 7'd0))
    else $error("kind none with nonzero payload");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_kind_r == l4cs_pkg::KIND_NONE || out_kind_r == l4cs_pkg::KIND_TCP ||
                     out_kind_r == l4cs_pkg::KIND_UDP))
    else $error("illegal segment kind");

  a_tcp_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == l4cs_pkg::KIND_TCP) |-> (out_ofs_r >= 7'd50))
    else $error("TCP checksum offset inside IP header");

  a_capture_drains: assert property (@(posedge clk) disable iff (!rst_n)
    s2_ld |=> out_valid_r)
    else $error("fold stage load lost");

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int MAX_FRAME   = 65535;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int HOLD_CYCLES  = 400;

  // frame offsets used by the checksum rules
  localparam int ETH_TYPE_OFS   = 12;
  localparam int IPV4_IHL_OFS   = 14;
  localparam int IPV6_NXT_OFS   = 20;
  localparam int IPV6_ADDR_OFS  = 22;
  localparam int IPV4_PROTO_OFS = 23;
  localparam int IPV4_ADDR_OFS  = 26;
  localparam int IPV4_ADDR_END  = 34;

  localparam logic [15:0] ETH_ARP    = 16'h0806;
  localparam logic [7:0]  PROTO_ICMP = 8'h01;

  typedef logic [7:0] frame_t[$];
  typedef enum int {FILL_RAND, FILL_ZERO, FILL_ONES} fill_e;

  typedef struct {
    logic [15:0] pos;
    logic [15:0] ether;
    logic [6:0]  hdr;
    logic [7:0]  proto;
    logic [31:0] acc;
    logic [7:0]  held;
    bit          too_long;
  } frame_acc_t;

  typedef struct {
    logic [15:0]     value;
    logic [6:0]      offset;
    l4cs_pkg::kind_t kind;
  } cksum_res_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] frame_byte
  logic        in_tlast = 1'b0; // last_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // [15:0] checksum_value, [22:16] field_offset, [23] zero
  logic [1:0]  out_tuser;       // [1:0] segment_kind

  frame_acc_t  frame_acc = '{default: '0};
  cksum_res_t  pending_cksums[$];

  int tx_gap_pct   = 0;
  int rx_stall_pct = 0;
  int hold_seq     = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int n_errors     = 0;
  int n_frames     = 0;
  int n_bytes      = 0;
  int n_checked    = 0;
  int n_kind[3]    = '{0, 0, 0};
  int cycle_cnt    = 0;

  l4_checksum_recompute_unit #(.MAX_FRAME(MAX_FRAME)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               pending_cksums.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // checksum predictor
  // ---------------------------------------------------------------------------
  function automatic bit is_ipv4(frame_acc_t s);
    return s.ether == l4cs_pkg::ETH_IPV4 && s.hdr >= l4cs_pkg::IPV4_MIN_HDR;
  endfunction

  function automatic int unsigned seg_base(frame_acc_t s);
    int unsigned hdr = 32'(s.hdr);
    if (is_ipv4(s)) return 32'(l4cs_pkg::ETH_HDR_BYTES) + hdr;
    if (s.ether == l4cs_pkg::ETH_IPV6) return 32'(l4cs_pkg::IPV6_SEG_START);
    return 0;
  endfunction

  function automatic int unsigned cksum_pos(frame_acc_t s);
    int unsigned base = seg_base(s);
    if (base == 0) return 0;
    if (s.proto == l4cs_pkg::PROTO_TCP) return base + 32'(l4cs_pkg::TCP_CK_OFS);
    if (s.proto == l4cs_pkg::PROTO_UDP) return base + 32'(l4cs_pkg::UDP_CK_OFS);
    return 0;
  endfunction

  // q is the even offset of the word's high byte
  function automatic bit word_in_sum(frame_acc_t s, int unsigned q);
    int unsigned ck = cksum_pos(s);
    int unsigned hdr = 32'(s.hdr);
    if (ck != 0 && q == ck) return 1'b0;
    if (is_ipv4(s))
      return (q >= IPV4_ADDR_OFS && q < IPV4_ADDR_END) ||
             q >= 32'(l4cs_pkg::ETH_HDR_BYTES) + hdr;
    if (s.ether == l4cs_pkg::ETH_IPV6) return q >= IPV6_ADDR_OFS;
    return 1'b0;
  endfunction

  function automatic void frame_step(inout frame_acc_t s, input logic [7:0] b,
                                     input bit last, output bit done,
                                     output cksum_res_t r);
    int unsigned p = 32'(s.pos);
    int unsigned len, base, ck, need, total;
    done = last;
    r = '{value: '0, offset: '0, kind: l4cs_pkg::KIND_NONE};
    if (p >= MAX_FRAME) begin
      s.too_long = 1'b1;
    end else begin
      if (p == ETH_TYPE_OFS) s.ether = {b, 8'h00};
      if (p == ETH_TYPE_OFS + 1) s.ether[7:0] = b;
      if (p == IPV4_IHL_OFS && s.ether == l4cs_pkg::ETH_IPV4) s.hdr = {1'b0, b[3:0], 2'b00};
      if (p == IPV4_PROTO_OFS && s.ether == l4cs_pkg::ETH_IPV4) s.proto = b;
      if (p == IPV6_NXT_OFS && s.ether == l4cs_pkg::ETH_IPV6) s.proto = b;
      if (p % 2 == 0) begin
        s.held = b;
        // odd tail: pad with a zero low byte
        if (last && word_in_sum(s, p)) s.acc += {16'h0, b, 8'h00};
      end else if (word_in_sum(s, p - 1)) begin
        s.acc += {16'h0, s.held, b};
      end
      s.pos = 16'(p + 1);
    end
    if (!last) return;

    len  = 32'(s.pos);
    base = seg_base(s);
    ck   = cksum_pos(s);
    need = (s.proto == l4cs_pkg::PROTO_TCP) ? 32'(l4cs_pkg::TCP_MIN_SEG) :
                                              32'(l4cs_pkg::UDP_MIN_SEG);
    if (!s.too_long && base != 0 && ck != 0 && len >= base + need) begin
      total = s.acc + 32'(s.proto) + (len - base);
      total = (total >> 16) + (total & 32'h0000ffff);
      total = (total >> 16) + (total & 32'h0000ffff);
      r.value  = ~total[15:0];
      r.offset = ck[6:0];
      r.kind   = (s.proto == l4cs_pkg::PROTO_TCP) ? l4cs_pkg::KIND_TCP : l4cs_pkg::KIND_UDP;
    end
    s = '{default: '0};
  endfunction

  // ---------------------------------------------------------------------------
  // frame source
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input bit last);
    bit done;
    cksum_res_t r;
    while (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_bytes++;
    frame_step(frame_acc, b, last, done, r);
    if (done) pending_cksums.push_back(r);
  endtask

  task automatic send_frame(input frame_t f);
    for (int i = 0; i < f.size(); i++) send_byte(f[i], i == f.size() - 1);
    n_frames++;
  endtask

  function automatic frame_t make_frame(logic [15:0] etype, logic [3:0] ihl,
                                        logic [7:0] proto, int seg_len, fill_e fill);
    frame_t f;
    int hdr_len, total;
    if (etype == l4cs_pkg::ETH_IPV6)
      hdr_len = int'(l4cs_pkg::IPV6_SEG_START) - int'(l4cs_pkg::ETH_HDR_BYTES);
    else if (etype == l4cs_pkg::ETH_IPV4 && ihl >= 4'd5) hdr_len = 4 * int'(ihl);
    else hdr_len = int'(l4cs_pkg::IPV4_MIN_HDR);
    total = int'(l4cs_pkg::ETH_HDR_BYTES) + hdr_len + seg_len;
    for (int i = 0; i < total; i++)
      f.push_back(fill == FILL_ZERO ? 8'h00 : fill == FILL_ONES ? 8'hff : 8'($urandom));
    f[ETH_TYPE_OFS]     = etype[15:8];
    f[ETH_TYPE_OFS + 1] = etype[7:0];
    if (etype == l4cs_pkg::ETH_IPV4) begin
      f[IPV4_IHL_OFS]   = (f[IPV4_IHL_OFS] & 8'hf0) | {4'h0, ihl};
      f[IPV4_PROTO_OFS] = proto;
    end else if (etype == l4cs_pkg::ETH_IPV6) begin
      f[IPV6_NXT_OFS] = proto;
    end
    return f;
  endfunction

  // ---------------------------------------------------------------------------
  // result sink and checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cksum_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_cksums.size() == 0) begin
        $error("result transfer with no frame pending: tdata %h tuser %h",
               out_tdata, out_tuser);
        n_errors++;
      end else begin
        want = pending_cksums.pop_front();
        if (out_tdata[15:0] !== want.value) begin
          $error("checksum_value: expected %h, got %h", want.value, out_tdata[15:0]);
          n_errors++;
        end
        if (out_tdata[22:16] !== want.offset) begin
          $error("field_offset: expected %0d, got %0d", want.offset, out_tdata[22:16]);
          n_errors++;
        end
        if (out_tuser !== want.kind) begin
          $error("segment_kind: expected %0d, got %0d", want.kind, out_tuser);
          n_errors++;
        end
        n_checked++;
        n_kind[want.kind]++;
      end
    end
    if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_directed_frames();
    frame_t f;
    frame_acc_t scratch;
    bit done;
    cksum_res_t r;
    f = {8'hff};  // frame ends before the ethertype
    send_frame(f);
    send_frame(make_frame(ETH_ARP, 4'd5, l4cs_pkg::PROTO_TCP, 6, FILL_RAND));
    send_frame(make_frame(l4cs_pkg::ETH_IPV4, 4'd5, l4cs_pkg::PROTO_TCP,
                          int'(l4cs_pkg::TCP_MIN_SEG), FILL_RAND));
    send_frame(make_frame(l4cs_pkg::ETH_IPV4, 4'd5, l4cs_pkg::PROTO_TCP,
                          int'(l4cs_pkg::TCP_MIN_SEG) - 1, FILL_RAND));
    send_frame(make_frame(l4cs_pkg::ETH_IPV4, 4'd5, l4cs_pkg::PROTO_UDP,
                          int'(l4cs_pkg::UDP_MIN_SEG), FILL_ZERO));
    send_frame(make_frame(l4cs_pkg::ETH_IPV4, 4'd5, l4cs_pkg::PROTO_UDP,
                          int'(l4cs_pkg::UDP_MIN_SEG) - 1, FILL_RAND));
    send_frame(make_frame(l4cs_pkg::ETH_IPV4, 4'd4, l4cs_pkg::PROTO_TCP, 10, FILL_RAND));
    send_frame(make_frame(l4cs_pkg::ETH_IPV4, 4'd15, l4cs_pkg::PROTO_TCP, 21, FILL_ONES));
    send_frame(make_frame(l4cs_pkg::ETH_IPV4, 4'd5, PROTO_ICMP, 6, FILL_RAND));
    send_frame(make_frame(l4cs_pkg::ETH_IPV6, 4'd0, l4cs_pkg::PROTO_TCP, 19, FILL_ZERO));
    send_frame(make_frame(l4cs_pkg::ETH_IPV6, 4'd0, l4cs_pkg::PROTO_UDP, 9, FILL_ONES));
    send_frame(make_frame(l4cs_pkg::ETH_IPV6, 4'd0, PROTO_ICMP, 4, FILL_RAND));

    // UDP frame whose checksum comes out as zero: patch the tail word with
    // the checksum computed over the frame with that word cleared
    f = make_frame(l4cs_pkg::ETH_IPV4, 4'd5, l4cs_pkg::PROTO_UDP, 12, FILL_RAND);
    f[f.size() - 2] = 8'h00;
    f[f.size() - 1] = 8'h00;
    scratch = '{default: '0};
    for (int i = 0; i < f.size(); i++)
      frame_step(scratch, f[i], i == f.size() - 1, done, r);
    f[f.size() - 2] = r.value[15:8];
    f[f.size() - 1] = r.value[7:0];
    send_frame(f);
  endtask

  task automatic test_random_frames(input int n);
    frame_t f;
    int sel, seg, cut;
    logic [15:0] et;
    logic [7:0] pr;
    logic [3:0] ihl;
    fill_e fill;
    repeat (n) begin
      sel  = int'($urandom_range(99));
      et   = $urandom_range(1) ? l4cs_pkg::ETH_IPV4 : l4cs_pkg::ETH_IPV6;
      pr   = $urandom_range(1) ? l4cs_pkg::PROTO_TCP : l4cs_pkg::PROTO_UDP;
      ihl  = 4'($urandom_range(15, 5));
      seg  = int'((pr == l4cs_pkg::PROTO_TCP) ? l4cs_pkg::TCP_MIN_SEG : l4cs_pkg::UDP_MIN_SEG)
             - 2 + int'($urandom_range(40));
      cut  = int'($urandom_range(19));
      fill = (cut == 0) ? FILL_ZERO : (cut == 1) ? FILL_ONES : FILL_RAND;
      if (sel < 10) ihl = 4'($urandom_range(4));
      else if (sel < 20) pr = 8'($urandom);
      else if (sel < 30) et = 16'($urandom);
      f = make_frame(et, ihl, pr, seg, fill);
      if (sel >= 90) begin
        cut = int'($urandom_range(f.size() - 1, 1));
        f = f[0:cut - 1];
      end
      send_frame(f);
    end
  endtask

  // receiver holds off while short frames keep coming, so the input stalls
  task automatic test_output_stall();
    frame_t f;
    hold_seq++;
    repeat (12) begin
      f = {8'($urandom)};
      send_frame(f);
    end
    send_frame(make_frame(l4cs_pkg::ETH_IPV4, 4'd5, l4cs_pkg::PROTO_UDP,
                          int'(l4cs_pkg::UDP_MIN_SEG), FILL_RAND));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_gap_pct   = 32;
    rx_stall_pct = 75;
    test_directed_frames();
    test_random_frames(3);

    tx_gap_pct   = 75;
    rx_stall_pct = 32;
    test_random_frames(2);

    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    test_random_frames(2);
    test_output_stall();
    in_tvalid <= 1'b0;

    while (pending_cksums.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("sent %0d frames (%0d bytes); checked %0d results", n_frames, n_bytes,
             n_checked);
    $display("results by kind: none %0d, tcp %0d, udp %0d", n_kind[l4cs_pkg::KIND_NONE],
             n_kind[l4cs_pkg::KIND_TCP], n_kind[l4cs_pkg::KIND_UDP]);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
